// ----- hdl/lcrk_pkg.sv -----
// ----------------------------------------------------------------------------
// lcrk_pkg
// Shared types, constants and helpers of the LC circuit RK4 step block.
// ----------------------------------------------------------------------------
package lcrk_pkg;

  localparam int unsigned VALUE_FRAC_BITS = 16;
  localparam int unsigned STEP_FRAC_BITS  = 40;
  localparam int unsigned SIXTH_GUARD     = 16;

  // floor(y / 3) = (y * DIV3_MULT) >> DIV3_SHIFT for every y below 2^DIV3_SHIFT
  localparam int unsigned DIV3_SHIFT = 47;
  localparam logic [47:0] DIV3_MULT  = 48'((64'd1 << DIV3_SHIFT) / 64'd3 + 64'd1);

  localparam int unsigned PADDR_W = 5;

  localparam logic [63:0] INV_C_RESET_RAW =
    ((64'd1000000 << VALUE_FRAC_BITS) + 64'd24) / 64'd48;
  localparam logic [63:0] INV_L_RESET_RAW =
    ((64'd1000000 << VALUE_FRAC_BITS) + 64'd11) / 64'd22;
  localparam logic [47:0] INV_C_RESET = INV_C_RESET_RAW[47:0];
  localparam logic [47:0] INV_L_RESET = INV_L_RESET_RAW[47:0];

  localparam logic signed [63:0] VOLT_RESET_RAW = 64'sd10000 <<< VALUE_FRAC_BITS;
  localparam logic signed [31:0] VOLT_RESET =
    (VOLT_RESET_RAW > 64'sd2147483647) ? 32'sh7FFF_FFFF : VOLT_RESET_RAW[31:0];

  typedef enum logic [1:0] {
    OP_STEP        = 2'd0,
    OP_SET_CURRENT = 2'd1,
    OP_RESTART     = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    REG_INV_C  = 2'd0,
    REG_INV_L  = 2'd1,
    REG_INIT_V = 2'd2,
    REG_INIT_I = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SH_VALUE,
    SH_HALF,
    SH_FULL,
    SH_COMB,
    SH_DIV3
  } sh_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QDIV,
    ST_KV,
    ST_NEG,
    ST_KI,
    ST_UV,
    ST_UI,
    ST_DBL,
    ST_ACC,
    ST_FV,
    ST_FI,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        step_length;
    logic signed [31:0] diode_voltage;
    logic signed [31:0] new_current;
  } in_t;

  typedef struct packed {
    logic signed [31:0] voltage_out;
    logic signed [31:0] current_out;
    logic [63:0]        time_out;
  } out_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic [47:0]        b;
    sh_sel_e            sh;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } mul_rsp_t;

  function automatic logic [127:0] round_const(input sh_sel_e sh);
    logic [127:0] r;
    case (sh)
      SH_VALUE: r = 128'd1 << (VALUE_FRAC_BITS - 1);
      SH_HALF:  r = 128'd1 << STEP_FRAC_BITS;
      SH_FULL:  r = 128'd1 << (STEP_FRAC_BITS - 1);
      SH_COMB:  r = 128'd1 << (STEP_FRAC_BITS + SIXTH_GUARD - 1);
      SH_DIV3:  r = '0;
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/lc_circuit_rk4_step.sv -----
// ----------------------------------------------------------------------------
// lc_circuit_rk4_step
// One RK4 step of a diode-driven series LC loop, sequenced over a shared
// 32x32 multiplier.
// Integrate beat with nonzero step: 17 products on the shared multiplier, plus
// sequencing, before the result is loaded once the output register is free.
// Other beats go from accept through ST_DONE to the output register.
// Next beat is taken the cycle after the result is loaded into the output
// register, so no new beat is taken while a step is still in progress.
// Reset: state to 10 kV / 0 A / time 0, registers to their defaults.
// ----------------------------------------------------------------------------
module lc_circuit_rk4_step import lcrk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam logic [1:0] LAST_STAGE  = 2'd3;
  localparam logic [1:0] FULL_UPDATE = 2'd2;
  localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (b > 64'sd0 && s > SUM_MAX) return SUM_MAX[63:0];
    if (b < 64'sd0 && s < -SUM_MAX) return 64'(-SUM_MAX);
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  state_e             state_q, state_d;
  logic               issued_q;
  logic               out_vld_q;
  out_t               out_q;
  logic signed [31:0] cap_q, cur_q;
  logic [63:0]        time_q;
  logic [47:0]        inv_c_q, inv_l_q;
  logic signed [31:0] init_v_q, init_i_q;

  logic [31:0]        dt_q;
  logic [47:0]        q_q;
  logic signed [63:0] vd_q, vs_q, is_q, kv_q, ki_q, sv_q, si_q;
  logic [1:0]         stage_q;

  mul_req_t           mul_req;
  mul_rsp_t           mul_rsp;
  logic               in_acc, out_load, cfg_we;
  logic signed [63:0] v0, i0, div_arg;
  logic [64:0]        tsum;

  assign v0      = {{32{cap_q[31]}}, cap_q};
  assign i0      = {{32{cur_q[31]}}, cur_q};
  assign div_arg = $signed(({32'b0, dt_q} << (SIXTH_GUARD - 1)) + 64'd1);
  assign tsum    = {1'b0, time_q} + {33'b0, dt_q};
  assign in_acc  = in_valid_i && in_ready_o;
  assign cfg_we  = psel && penable && pwrite && pready;

  lcrk_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_i.opcode == OP_STEP && in_i.step_length != '0) state_d = ST_QDIV;
          else state_d = ST_DONE;
        end
      end
      ST_QDIV: if (mul_rsp.done) state_d = ST_KV;
      ST_KV:   if (mul_rsp.done) state_d = ST_NEG;
      ST_NEG:  state_d = ST_KI;
      ST_KI: begin
        if (mul_rsp.done) state_d = (stage_q == LAST_STAGE) ? ST_DBL : ST_UV;
      end
      ST_UV:   if (mul_rsp.done) state_d = ST_UI;
      ST_UI:   if (mul_rsp.done) state_d = ST_DBL;
      ST_DBL:  state_d = ST_ACC;
      ST_ACC:  state_d = (stage_q == LAST_STAGE) ? ST_FV : ST_KV;
      ST_FV:   if (mul_rsp.done) state_d = ST_FI;
      ST_FI:   if (mul_rsp.done) state_d = ST_DONE;
      ST_DONE: if (!out_vld_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    out_load      = (state_q == ST_DONE) && (!out_vld_q || out_ready_i);
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    mul_req.sh    = SH_VALUE;
    case (state_q)
      ST_QDIV: begin
        mul_req.start = !issued_q;
        mul_req.a     = div_arg;
        mul_req.b     = DIV3_MULT;
        mul_req.sh    = SH_DIV3;
      end
      ST_KV: begin
        mul_req.start = !issued_q;
        mul_req.a     = is_q;
        mul_req.b     = inv_c_q;
      end
      ST_KI: begin
        mul_req.start = !issued_q;
        mul_req.a     = ki_q;
        mul_req.b     = inv_l_q;
      end
      ST_UV, ST_UI: begin
        mul_req.start = !issued_q;
        mul_req.a     = (state_q == ST_UV) ? kv_q : ki_q;
        mul_req.b     = {16'b0, dt_q};
        mul_req.sh    = (stage_q == FULL_UPDATE) ? SH_FULL : SH_HALF;
      end
      ST_FV, ST_FI: begin
        mul_req.start = !issued_q;
        mul_req.a     = (state_q == ST_FV) ? sv_q : si_q;
        mul_req.b     = q_q;
        mul_req.sh    = SH_COMB;
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issued_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cap_q     <= VOLT_RESET;
      cur_q     <= '0;
      time_q    <= '0;
      inv_c_q   <= INV_C_RESET;
      inv_l_q   <= INV_L_RESET;
      init_v_q  <= VOLT_RESET;
      init_i_q  <= '0;
    end else begin
      state_q <= state_d;
      if (mul_req.start) issued_q <= 1'b1;
      else if (mul_rsp.done) issued_q <= 1'b0;
      if (out_load) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;

      if (in_acc) begin
        case (in_i.opcode)
          OP_SET_CURRENT: cur_q <= in_i.new_current;
          OP_RESTART: begin
            cap_q  <= init_v_q;
            cur_q  <= init_i_q;
            time_q <= '0;
          end
          default: begin
            cur_q <= cur_q;
          end
        endcase
      end
      if (state_q == ST_FV && mul_rsp.done) cap_q <= sat32(sat_add(v0, mul_rsp.res));
      if (state_q == ST_FI && mul_rsp.done) begin
        cur_q  <= sat32(sat_add(i0, mul_rsp.res));
        time_q <= tsum[64] ? '1 : tsum[63:0];
      end

      if (cfg_we) begin
        case (cfg_reg_e'(paddr[PADDR_W-1:3]))
          REG_INV_C:  inv_c_q  <= pwdata[47:0];
          REG_INV_L:  inv_l_q  <= pwdata[47:0];
          REG_INIT_V: init_v_q <= pwdata[31:0];
          REG_INIT_I: init_i_q <= pwdata[31:0];
          default:    inv_c_q  <= inv_c_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.voltage_out <= cap_q;
      out_q.current_out <= cur_q;
      out_q.time_out    <= time_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          dt_q    <= in_i.step_length;
          vd_q    <= {{32{in_i.diode_voltage[31]}}, in_i.diode_voltage};
          vs_q    <= v0;
          is_q    <= i0;
          sv_q    <= '0;
          si_q    <= '0;
          stage_q <= '0;
        end
      end
      ST_QDIV: if (mul_rsp.done) q_q <= mul_rsp.res[47:0];
      ST_KV:   if (mul_rsp.done) kv_q <= mul_rsp.res;
      ST_NEG:  ki_q <= -sat_add(vs_q, vd_q);
      ST_KI:   if (mul_rsp.done) ki_q <= mul_rsp.res;
      ST_UV:   if (mul_rsp.done) vs_q <= sat_add(v0, mul_rsp.res);
      ST_UI:   if (mul_rsp.done) is_q <= sat_add(i0, mul_rsp.res);
      ST_DBL: begin
        if (stage_q != '0 && stage_q != LAST_STAGE) begin
          kv_q <= sat_add(kv_q, kv_q);
          ki_q <= sat_add(ki_q, ki_q);
        end
      end
      ST_ACC: begin
        sv_q    <= sat_add(sv_q, kv_q);
        si_q    <= sat_add(si_q, ki_q);
        stage_q <= stage_q + 2'd1;
      end
      default: begin
        dt_q <= dt_q;
      end
    endcase
  end

  always_comb begin
    case (cfg_reg_e'(paddr[PADDR_W-1:3]))
      REG_INV_C:  prdata = {16'b0, inv_c_q};
      REG_INV_L:  prdata = {16'b0, inv_l_q};
      REG_INIT_V: prdata = {{32{init_v_q[31]}}, init_v_q};
      REG_INIT_I: prdata = {{32{init_i_q[31]}}, init_i_q};
      default:    prdata = '0;
    endcase
  end

  assign pready      = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  a_zero_step_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.opcode == OP_STEP && in_i.step_length == '0)
      |=> ($stable(time_q) && $stable(cap_q) && $stable(cur_q)))
    else $error("zero step changed state");

  a_restart_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.opcode == OP_RESTART)
      |=> (time_q == '0 && cap_q == $past(init_v_q) && cur_q == $past(init_i_q)))
    else $error("restart did not load initial state");

  a_time_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && in_i.opcode == OP_RESTART) |=> (time_q >= $past(time_q)))
    else $error("elapsed time went backward");

endmodule

// ----- hdl/lcrk_mul.sv -----
// ----------------------------------------------------------------------------
// lcrk_mul
// Shared signed-by-unsigned multiplier with rounding shift and saturation.
// One 32x32 partial product a cycle, accumulated at 128 bits.
// ----------------------------------------------------------------------------
module lcrk_mul import lcrk_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam logic [2:0] LAST_PP  = 3'd3;
  localparam logic [2:0] FIN_STEP = 3'd5;

  logic               busy_q, done_q, pp_vld_q;
  logic [2:0]         cnt_q;
  logic [63:0]        mag_q;
  logic [47:0]        b_q;
  logic               neg_q;
  sh_sel_e            sh_q;
  logic [127:0]       acc_q;
  logic [63:0]        pp_q;
  logic [1:0]         pp_off_q;
  logic signed [63:0] res_q;

  logic [31:0]        ah, bh;
  logic [63:0]        pp_d;
  logic [127:0]       pp_sh;
  logic [127:0]       qv;
  logic [63:0]        mag_res;
  logic               issue, fin;

  assign issue = busy_q && (cnt_q <= LAST_PP);
  assign fin   = busy_q && (cnt_q == FIN_STEP);

  always_comb begin
    ah   = cnt_q[0] ? mag_q[63:32] : mag_q[31:0];
    bh   = cnt_q[1] ? {16'b0, b_q[47:32]} : b_q[31:0];
    pp_d = 64'(ah) * 64'(bh);
  end

  always_comb begin
    case (pp_off_q)
      2'd0:    pp_sh = {64'b0, pp_q};
      2'd1:    pp_sh = {32'b0, pp_q, 32'b0};
      2'd2:    pp_sh = {pp_q, 64'b0};
      default: pp_sh = '0;
    endcase
  end

  always_comb begin
    case (sh_q)
      SH_VALUE: qv = acc_q >> VALUE_FRAC_BITS;
      SH_HALF:  qv = acc_q >> (STEP_FRAC_BITS + 1);
      SH_FULL:  qv = acc_q >> STEP_FRAC_BITS;
      SH_COMB:  qv = acc_q >> (STEP_FRAC_BITS + SIXTH_GUARD);
      SH_DIV3:  qv = acc_q >> DIV3_SHIFT;
      default:  qv = acc_q;
    endcase
    mag_res = (|qv[127:63]) ? {1'b0, {63{1'b1}}} : {1'b0, qv[62:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      pp_vld_q <= 1'b0;
    end else begin
      done_q   <= fin;
      pp_vld_q <= issue;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (fin) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.a[63];
      mag_q <= req_i.a[63] ? 64'(-req_i.a) : 64'(req_i.a);
      b_q   <= req_i.b;
      sh_q  <= req_i.sh;
      acc_q <= round_const(req_i.sh);
    end else if (pp_vld_q) begin
      acc_q <= acc_q + pp_sh;
    end
    if (issue) begin
      pp_q     <= pp_d;
      pp_off_q <= 2'({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]});
    end
    if (fin) begin
      res_q <= neg_q ? -$signed(mag_res) : $signed(mag_res);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("multiply started while busy");

  a_done_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> ##7 done_q)
    else $error("multiply result late");

  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiply done held");

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives lc_circuit_rk4_step with opcode beats and register writes over APB.
// Predicts the voltage, current and elapsed time of every result beat. The
// predictor is a bit-exact fixed-point RK4 step. The run goes through several
// register settings and idle patterns, including one long output hold-off.
// ----------------------------------------------------------------------------
module testbench import lcrk_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam longint      WIDE_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint      I32_MAX     = 64'sd2147483647;
  localparam longint      I32_MIN     = -64'sd2147483648;
  localparam int unsigned PHASE_ITEMS = 124;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned HOLD_CYCLES = 800;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_t                in_i        = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_t               out_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [63:0]        pwdata      = '0;
  logic [63:0]        prdata;
  logic               pready;

  in_t  pending_items[$];
  out_t expected_states[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        holdoff_go     = 1'b0;
  logic        rx_hold        = 1'b0;
  int unsigned fail_count     = 0;

  logic [47:0]        cfg_inv_c    = INV_C_RESET;
  logic [47:0]        cfg_inv_l    = INV_L_RESET;
  logic signed [31:0] cfg_init_v   = VOLT_RESET;
  logic signed [31:0] cfg_init_i   = '0;
  logic signed [31:0] loop_volt    = VOLT_RESET;
  logic signed [31:0] loop_amp     = '0;
  logic [63:0]        loop_elapsed = '0;

  lc_circuit_rk4_step i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp_add(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > WIDE_MAX) return WIDE_MAX;
    if (s < -WIDE_MAX) return -WIDE_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > I32_MAX) return 32'sh7FFF_FFFF;
    if (v < I32_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // round half away from zero, then saturate to +-WIDE_MAX
  function automatic longint scaled_product(longint a, logic [63:0] b, int unsigned sh);
    logic [63:0]  mag;
    logic [127:0] p;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    p = ({64'd0, mag} * {64'd0, b} + (128'd1 << (sh - 1))) >> sh;
    if (p > 128'(WIDE_MAX)) p = 128'(WIDE_MAX);
    return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic void slopes(input longint v, input longint i, input longint vd,
                                 output longint kv, output longint ki);
    kv = scaled_product(i, 64'(cfg_inv_c), VALUE_FRAC_BITS);
    ki = scaled_product(-clamp_add(v, vd), 64'(cfg_inv_l), VALUE_FRAC_BITS);
  endfunction

  function automatic void rk4_update(logic [31:0] dt, longint vd);
    longint      v0, i0, k1v, k1i, k2v, k2i, k3v, k3i, k4v, k4i, sv, si;
    logic [63:0] sixth;
    logic [64:0] tsum;
    v0 = longint'(loop_volt);
    i0 = longint'(loop_amp);
    sixth = ((64'(dt) << SIXTH_GUARD) + 64'd3) / 64'd6;
    slopes(v0, i0, vd, k1v, k1i);
    slopes(clamp_add(v0, scaled_product(k1v, 64'(dt), STEP_FRAC_BITS + 1)),
           clamp_add(i0, scaled_product(k1i, 64'(dt), STEP_FRAC_BITS + 1)), vd, k2v, k2i);
    slopes(clamp_add(v0, scaled_product(k2v, 64'(dt), STEP_FRAC_BITS + 1)),
           clamp_add(i0, scaled_product(k2i, 64'(dt), STEP_FRAC_BITS + 1)), vd, k3v, k3i);
    slopes(clamp_add(v0, scaled_product(k3v, 64'(dt), STEP_FRAC_BITS)),
           clamp_add(i0, scaled_product(k3i, 64'(dt), STEP_FRAC_BITS)), vd, k4v, k4i);
    sv = clamp_add(clamp_add(clamp_add(k1v, clamp_add(k2v, k2v)), clamp_add(k3v, k3v)), k4v);
    si = clamp_add(clamp_add(clamp_add(k1i, clamp_add(k2i, k2i)), clamp_add(k3i, k3i)), k4i);
    loop_volt = clamp32(clamp_add(v0, scaled_product(sv, sixth, STEP_FRAC_BITS + SIXTH_GUARD)));
    loop_amp  = clamp32(clamp_add(i0, scaled_product(si, sixth, STEP_FRAC_BITS + SIXTH_GUARD)));
    tsum = {1'b0, loop_elapsed} + 65'(dt);
    loop_elapsed = tsum[64] ? '1 : tsum[63:0];
  endfunction

  function automatic out_t advance_loop(in_t item);
    out_t res;
    case (item.opcode)
      OP_STEP: begin
        if (item.step_length != '0) begin
          rk4_update(item.step_length, longint'($signed(item.diode_voltage)));
        end
      end
      OP_SET_CURRENT: begin
        loop_amp = item.new_current;
      end
      OP_RESTART: begin
        loop_volt    = cfg_init_v;
        loop_amp     = cfg_init_i;
        loop_elapsed = '0;
      end
      default: ;
    endcase
    res.voltage_out = loop_volt;
    res.current_out = loop_amp;
    res.time_out    = loop_elapsed;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
    end else begin
      if (in_valid_i && in_ready_o) expected_states.push_back(advance_loop(in_i));
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_i       <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_states.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result beat with nothing expected: %h", out_o);
        end else begin
          check_field("voltage_out", 64'(expected_states[0].voltage_out),
                      64'(out_o.voltage_out));
          check_field("current_out", 64'(expected_states[0].current_out),
                      64'(out_o.current_out));
          check_field("time_out", expected_states[0].time_out, out_o.time_out);
          void'(expected_states.pop_front());
        end
      end
      out_ready_i <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : output_holdoff
    wait (holdoff_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #15_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic write_register(cfg_reg_e which, logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({which, 3'b000});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (which)
      REG_INV_C:  cfg_inv_c  = value[47:0];
      REG_INV_L:  cfg_inv_l  = value[47:0];
      REG_INIT_V: cfg_init_v = value[31:0];
      REG_INIT_I: cfg_init_i = value[31:0];
      default: ;
    endcase
  endtask

  task automatic program_loop(logic [47:0] inv_c, logic [47:0] inv_l,
                              logic signed [31:0] init_v, logic signed [31:0] init_i);
    write_register(REG_INV_C, {16'h0, inv_c});
    write_register(REG_INV_L, {16'h0, inv_l});
    write_register(REG_INIT_V, 64'(init_v));
    write_register(REG_INIT_I, 64'(init_i));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_states.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  function automatic in_t make_item(logic [1:0] op, logic [31:0] dt,
                                    logic [31:0] vd, logic [31:0] amps);
    in_t it;
    it.opcode        = op;
    it.step_length   = dt;
    it.diode_voltage = vd;
    it.new_current   = amps;
    return it;
  endfunction

  function automatic in_t random_item();
    in_t         it;
    int unsigned roll;
    roll = $urandom_range(99);
    it.step_length = $urandom >> $urandom_range(31);
    if ($urandom_range(9) == 0) it.step_length = '0;
    it.diode_voltage = $signed($urandom) >>> $urandom_range(24);
    it.new_current   = $signed($urandom) >>> $urandom_range(24);
    if (roll < 80) it.opcode = OP_STEP;
    else if (roll < 92) it.opcode = OP_SET_CURRENT;
    else if (roll < 97) it.opcode = OP_RESTART;
    else it.opcode = OP_UNUSED;
    return it;
  endfunction

  function automatic logic [47:0] random_inverse();
    logic [63:0] raw;
    raw = {$urandom, $urandom} >> $urandom_range(40, 16);
    return raw[47:0];
  endfunction

  initial begin : stimulus
    int unsigned counted;
    in_t         it;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    pending_items.push_back(make_item(OP_STEP, 32'h0010_0000, 32'h0, $urandom));
    pending_items.push_back(make_item(OP_STEP, 32'h0, $urandom, $urandom));
    pending_items.push_back(make_item(OP_UNUSED, $urandom, $urandom, $urandom));
    pending_items.push_back(make_item(OP_SET_CURRENT, 32'h0, 32'h0, 32'h7FFF_FFFF));
    pending_items.push_back(make_item(OP_STEP, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0));
    pending_items.push_back(make_item(OP_STEP, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0));
    pending_items.push_back(make_item(OP_SET_CURRENT, 32'h0, 32'h0, 32'h8000_0000));
    pending_items.push_back(make_item(OP_STEP, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0));
    pending_items.push_back(make_item(OP_RESTART, 32'h0, 32'h0, 32'h0));
    pending_items.push_back(make_item(OP_STEP, 32'h0000_0001, 32'h8000_0000, 32'h0));
    pending_items.push_back(make_item(OP_STEP, 32'h0000_1000, 32'hFFFF_FFFF, 32'h0));
    pending_items.push_back(make_item(OP_SET_CURRENT, 32'h0, 32'h0, 32'h0));
    pending_items.push_back(make_item(OP_STEP, 32'h0100_0000, 32'h0, 32'h0));
    pending_items.push_back(make_item(OP_RESTART, $urandom, $urandom, $urandom));
    repeat (4) pending_items.push_back(make_item(OP_STEP, 32'h0040_0000, 32'h0, 32'h0));
    pending_items.push_back(make_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(OP_SET_CURRENT, 32'hAAAA_AAAA, 32'h5555_5555,
                                      32'h5555_5555));
    pending_items.push_back(make_item(OP_STEP, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA));
    wait_drained();

    for (int k = 0; k < NUM_PHASES; k++) begin
      case (k)
        0: ;
        1: program_loop(48'h0, '1, 32'sh8000_0000, 32'sh7FFF_FFFF);
        2: program_loop('1, 48'h0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        4: program_loop(INV_C_RESET, INV_L_RESET, VOLT_RESET, 32'sh0);
        default: program_loop(random_inverse(), random_inverse(), $urandom, $urandom);
      endcase
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      pending_items.push_back(make_item(OP_RESTART, $urandom, $urandom, $urandom));
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = random_item();
        pending_items.push_back(it);
        if (it.opcode != OP_UNUSED && !(it.opcode == OP_STEP && it.step_length == '0)) begin
          counted++;
        end
      end
      if (k == 4) holdoff_go = 1'b1;
      wait_drained();
    end

    repeat (160) @(negedge clk_i);
    if (fail_count == 0 && expected_states.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- lc_circuit_rk4_step.f -----
hdl/lcrk_pkg.sv
hdl/lcrk_mul.sv
hdl/lc_circuit_rk4_step.sv
verif/testbench.sv
